### rtl/clb_pkg.sv
// Package for the circular line buffer: beat structs, sizes and codes.
// Used by circular_line_buffer_unit.
package clb_pkg;

  localparam int BUF_SIZE = 64;
  localparam int HEAD_W   = $clog2(BUF_SIZE);
  localparam int FILL_W   = $clog2(BUF_SIZE + 1);
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;
    logic              chunk_first;
    logic [LEN_W-1:0]  chunk_len;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] line_byte;
    logic              accepted;
    logic              last;
  } rsp_t;

endpackage

### rtl/circular_line_buffer_unit.sv
// Circular line buffer: byte ring of BUF_SIZE entries read out a line at a time.
// Depends on clb_pkg and clb_ram.
// Write beat: status beat in the cycle after accept; one write per cycle unless stalled.
// Read beat: n stored bytes are consumed (newline included), each held until known to be
// last; a flush beat is added when no newline is stored and n > 1; output stalls hold it.
// Reset (rst, synchronous): head, fill, chunk decision and control cleared; store not cleared.
module circular_line_buffer_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  clb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output clb_pkg::rsp_t rsp
);
  import clb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_FLUSH
  } state_t;

  state_t            state;
  logic [HEAD_W-1:0] head;
  logic [FILL_W-1:0] fill;
  logic              chunk_rejected;
  // held byte: a line byte is only sent once we know whether it is the last
  logic              hv;
  logic [BYTE_W-1:0] hb;

  logic              ofree;
  logic              req_take;
  logic [HEAD_W-1:0] head_inc;
  logic [FILL_W:0]   slot_sum;
  logic [HEAD_W-1:0] slot;
  logic [FILL_W-1:0] room;
  logic              full;
  logic              rej_new;
  logic              rej_eff;
  logic              wr_acc;
  logic              ram_we;
  logic              ram_re;
  logic [HEAD_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] rdata;
  logic              rd_nl;
  logic              rd_final;

  // output register is free when empty or being drained this cycle
  assign ofree     = !rsp_valid || !rsp_stall;
  assign req_stall = !(state == ST_IDLE && ofree);
  assign req_take  = req_valid && !req_stall;

  assign head_inc = (head == HEAD_W'(BUF_SIZE - 1)) ? '0 : head + HEAD_W'(1);

  // tail slot: head + fill stays below twice the buffer size
  assign slot_sum = (FILL_W + 1)'(head) + (FILL_W + 1)'(fill);
  assign slot     = (slot_sum >= (FILL_W + 1)'(BUF_SIZE))
                    ? HEAD_W'(slot_sum - (FILL_W + 1)'(BUF_SIZE))
                    : HEAD_W'(slot_sum);

  // chunk admission, decided on the first byte; a full ring refuses any byte
  assign full    = (fill >= FILL_W'(BUF_SIZE));
  assign room    = FILL_W'(BUF_SIZE) - fill;
  assign rej_new = full || (req.chunk_len > LEN_W'(room));
  assign rej_eff = req.chunk_first ? rej_new : chunk_rejected;
  assign wr_acc  = !rej_eff && !full;

  assign rd_nl    = (rdata == NEWLINE);
  assign rd_final = (fill == FILL_W'(1));

  assign ram_we    = req_take && (req.opcode == OP_WRITE) && wr_acc;
  assign ram_re    = (req_take && (req.opcode == OP_READ) && (fill != '0))
                  || (state == ST_RD && ofree && !rd_nl && !rd_final);
  assign ram_raddr = (state == ST_IDLE) ? head : head_inc;

  clb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (req.data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head           <= '0;
      fill           <= '0;
      chunk_rejected <= 1'b0;
      hv             <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_take) begin
            if (req.opcode == OP_WRITE) begin
              if (req.chunk_first) begin
                chunk_rejected <= rej_new;
              end
              if (wr_acc) begin
                fill <= fill + FILL_W'(1);
              end
              rsp       <= '{kind: KIND_STATUS, line_byte: '0, accepted: wr_acc, last: 1'b1};
              rsp_valid <= 1'b1;
            end else if (fill == '0) begin
              rsp       <= '{kind: KIND_EMPTY, line_byte: '0, accepted: 1'b0, last: 1'b1};
              rsp_valid <= 1'b1;
            end else begin
              hv    <= 1'b0;
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          // rdata holds the byte at head; it is consumed once the output is free
          if (ofree) begin
            head <= head_inc;
            fill <= fill - FILL_W'(1);
            if (rd_nl) begin
              rsp <= hv ? rsp_t'{kind: KIND_BYTE, line_byte: hb, accepted: 1'b0, last: 1'b1}
                        : rsp_t'{kind: KIND_EMPTY, line_byte: '0, accepted: 1'b0, last: 1'b1};
              rsp_valid <= 1'b1;
              hv        <= 1'b0;
              state     <= ST_IDLE;
            end else if (rd_final) begin
              // no newline stored: last byte of the ring ends the line
              if (hv) begin
                rsp   <= '{kind: KIND_BYTE, line_byte: hb, accepted: 1'b0, last: 1'b0};
                hb    <= rdata;
                state <= ST_FLUSH;
              end else begin
                rsp   <= '{kind: KIND_BYTE, line_byte: rdata, accepted: 1'b0, last: 1'b1};
                state <= ST_IDLE;
              end
              rsp_valid <= 1'b1;
              hv        <= 1'b0;
            end else begin
              if (hv) begin
                rsp       <= '{kind: KIND_BYTE, line_byte: hb, accepted: 1'b0, last: 1'b0};
                rsp_valid <= 1'b1;
              end
              hb <= rdata;
              hv <= 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (ofree) begin
            rsp       <= '{kind: KIND_BYTE, line_byte: hb, accepted: 1'b0, last: 1'b1};
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // occupancy never runs past the ring size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(BUF_SIZE))
    else $error("fill exceeds buffer size");

  // a read of a non-empty ring must start the RAM walk
  a_read_start: assert property (@(posedge clk) disable iff (rst)
    (req_take && req.opcode == OP_READ && fill != '0) |=> (state == ST_RD))
    else $error("read did not enter walk state");

  // the flush beat only follows draining the ring completely
  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (fill == '0))
    else $error("flush with bytes left");

  // a write never lands while a line walk holds the RAM
  a_no_wr_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !ram_we)
    else $error("store written during line read");

endmodule

### rtl/clb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module clb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
